/* hw/rtl/rhc_pkg.sv */
// Shared types, constants and the divider step for the RGB to HSV converter.
package rhc_pkg;

    localparam int CH_W       = 8;
    localparam int HUE_W      = 13;
    localparam int SAT_W      = 13;
    localparam int NUM_W      = 20;
    localparam int HUE_Q_W    = 10;
    localparam int DIV_STAGES = 5;
    localparam int DIV_STEPS  = NUM_W / DIV_STAGES;

    localparam int HUE_SIXTH  = 960;
    localparam int HUE_GREEN  = 1920;
    localparam int HUE_BLUE   = 3840;
    localparam int HUE_FULL   = 5760;
    localparam int SAT_SHIFT  = 12;

    typedef enum logic [1:0] {
        SEL_RED,
        SEL_GREEN,
        SEL_BLUE
    } hue_sel_t;

    typedef struct packed {
        logic [CH_W-1:0] value;
        logic [CH_W-1:0] delta;
        hue_sel_t        sel;
        logic            neg;
        logic [CH_W-1:0] mag;
    } front_t;

    typedef struct packed {
        logic [CH_W-1:0]    value;
        hue_sel_t           sel;
        logic               neg;
        logic               hv;
        logic [CH_W-1:0]    sat_d;
        logic [CH_W-1:0]    hue_d;
        logic [NUM_W-1:0]   sat_num;
        logic [NUM_W-1:0]   hue_num;
        logic [CH_W-1:0]    sat_rem;
        logic [CH_W-1:0]    hue_rem;
        logic [SAT_W-1:0]   sat_q;
        logic [HUE_Q_W-1:0] hue_q;
    } div_t;

    // One restoring step: returns {quotient bit, new remainder}.
    function automatic logic [CH_W:0] div_step(
        input logic [CH_W-1:0] rem,
        input logic            nbit,
        input logic [CH_W-1:0] d
    );
        logic [CH_W:0] part;
        logic [CH_W:0] diff;
        part = {rem, nbit};
        diff = part - {1'b0, d};
        if (part >= {1'b0, d})
        begin
            return {1'b1, diff[CH_W-1:0]};
        end
        return {1'b0, part[CH_W-1:0]};
    endfunction

endpackage

/* hw/rtl/rgb_to_hsv_convert_top.sv */
// RGB to HSV pixel converter: min/max front end, pipelined dividers, hue assembly.
// An accepted pixel passes the front-end register, the divider stage registers and the output register.
// Throughput: one pixel per clock while not stalled; the two restoring dividers
// (saturation and hue) run 4 quotient bits per stage over 5 stages, which sets the depth.
// Stalls back up stage by stage; empty stages fill while the output waits.
// Reset (rst_n, async, active low) clears all valid bits; data is not reset.
module rgb_to_hsv_convert_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       pix_valid,
    output logic                       pix_stall,
    input  logic [rhc_pkg::CH_W-1:0]   red,
    input  logic [rhc_pkg::CH_W-1:0]   green,
    input  logic [rhc_pkg::CH_W-1:0]   blue,
    output logic                       hsv_valid,
    input  logic                       hsv_stall,
    output logic [rhc_pkg::HUE_W-1:0]  hue,
    output logic                       hue_valid,
    output logic [rhc_pkg::SAT_W-1:0]  saturation,
    output logic [rhc_pkg::CH_W-1:0]   value
);
    import rhc_pkg::*;

    // Front end: max, min, hue sector and signed channel difference
    logic [CH_W-1:0] mx_c;
    logic [CH_W-1:0] mn_c;
    hue_sel_t        sel_c;
    logic [CH_W:0]   diff_c;
    logic [CH_W:0]   mag_c;
    front_t          front_next;
    front_t          front_reg;
    logic            front_v_reg;
    logic            front_rdy;

    div_t            div_reg  [0:DIV_STAGES];
    div_t            div_next [0:DIV_STAGES];
    logic            div_v_reg [0:DIV_STAGES];
    logic            div_rdy   [0:DIV_STAGES];

    logic               out_v_reg;
    logic               out_rdy;
    logic [HUE_W-1:0]   hue_reg;
    logic [HUE_W-1:0]   hue_next;
    logic               hue_valid_reg;
    logic [SAT_W-1:0]   sat_reg;
    logic [SAT_W-1:0]   sat_next;
    logic [CH_W-1:0]    value_reg;

    always_comb
    begin
        mx_c = red;
        mn_c = red;
        if (green > mx_c)
        begin
            mx_c = green;
        end
        if (blue > mx_c)
        begin
            mx_c = blue;
        end
        if (green < mn_c)
        begin
            mn_c = green;
        end
        if (blue < mn_c)
        begin
            mn_c = blue;
        end
        // ties go to red, then green
        priority if (red == mx_c)
        begin
            sel_c = SEL_RED;
        end
        else if (green == mx_c)
        begin
            sel_c = SEL_GREEN;
        end
        else
        begin
            sel_c = SEL_BLUE;
        end
        unique case (sel_c)
            SEL_RED:   diff_c = {1'b0, green} - {1'b0, blue};
            SEL_GREEN: diff_c = {1'b0, blue} - {1'b0, red};
            SEL_BLUE:  diff_c = {1'b0, red} - {1'b0, green};
            default:   diff_c = '0;
        endcase
        mag_c = diff_c[CH_W] ? (~diff_c + 1'b1) : diff_c;
        front_next.value = mx_c;
        front_next.delta = mx_c - mn_c;
        front_next.sel   = sel_c;
        front_next.neg   = diff_c[CH_W];
        front_next.mag   = mag_c[CH_W-1:0];
    end

    // Ready chain: a stage loads when it is empty or its successor moves
    always_comb
    begin
        out_rdy = !out_v_reg || !hsv_stall;
        div_rdy[DIV_STAGES] = !div_v_reg[DIV_STAGES] || out_rdy;
        for (int k = DIV_STAGES - 1; k >= 0; k--)
        begin
            div_rdy[k] = !div_v_reg[k] || div_rdy[k+1];
        end
        front_rdy = !front_v_reg || div_rdy[0];
    end

    assign pix_stall = !front_rdy;

    // Numerator setup: scaled delta for saturation, 960*|diff| for hue
    always_comb
    begin
        div_next[0].value   = front_reg.value;
        div_next[0].sel     = front_reg.sel;
        div_next[0].neg     = front_reg.neg;
        div_next[0].hv      = (front_reg.delta != '0);
        div_next[0].sat_d   = front_reg.value;
        div_next[0].hue_d   = front_reg.delta;
        div_next[0].sat_num = {front_reg.delta, {SAT_SHIFT{1'b0}}};
        div_next[0].hue_num = NUM_W'(front_reg.mag) * NUM_W'(HUE_SIXTH);
        div_next[0].sat_rem = '0;
        div_next[0].hue_rem = '0;
        div_next[0].sat_q   = '0;
        div_next[0].hue_q   = '0;
    end

    for (genvar k = 1; k <= DIV_STAGES; k++)
    begin : g_div
        always_comb
        begin
            div_t          nxt;
            logic [CH_W:0] s_step;
            logic [CH_W:0] h_step;
            nxt = div_reg[k-1];
            for (int i = 0; i < DIV_STEPS; i++)
            begin
                s_step = div_step(nxt.sat_rem, nxt.sat_num[NUM_W-1], nxt.sat_d);
                h_step = div_step(nxt.hue_rem, nxt.hue_num[NUM_W-1], nxt.hue_d);
                nxt.sat_rem = s_step[CH_W-1:0];
                nxt.hue_rem = h_step[CH_W-1:0];
                nxt.sat_q   = {nxt.sat_q[SAT_W-2:0], s_step[CH_W]};
                nxt.hue_q   = {nxt.hue_q[HUE_Q_W-2:0], h_step[CH_W]};
                nxt.sat_num = nxt.sat_num << 1;
                nxt.hue_num = nxt.hue_num << 1;
            end
            div_next[k] = nxt;
        end
    end

    // Hue assembly: sector base plus or minus quotient, wrap negatives
    always_comb
    begin
        logic signed [HUE_W:0] base;
        logic signed [HUE_W:0] hq;
        logic signed [HUE_W:0] h;
        unique case (div_reg[DIV_STAGES].sel)
            SEL_RED:   base = '0;
            SEL_GREEN: base = (HUE_W+1)'(HUE_GREEN);
            SEL_BLUE:  base = (HUE_W+1)'(HUE_BLUE);
            default:   base = '0;
        endcase
        hq = $signed({{(HUE_W+1-HUE_Q_W){1'b0}}, div_reg[DIV_STAGES].hue_q});
        h  = div_reg[DIV_STAGES].neg ? (base - hq) : (base + hq);
        if (h < 0)
        begin
            h = h + (HUE_W+1)'(HUE_FULL);
        end
        hue_next = div_reg[DIV_STAGES].hv ? h[HUE_W-1:0] : '0;
        // black: divider saw a zero divisor, drop its quotient
        sat_next = (div_reg[DIV_STAGES].value == '0) ? '0 : div_reg[DIV_STAGES].sat_q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_v_reg <= 1'b0;
            for (int k = 0; k <= DIV_STAGES; k++)
            begin
                div_v_reg[k] <= 1'b0;
            end
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (front_rdy)
            begin
                front_v_reg <= pix_valid;
            end
            if (div_rdy[0])
            begin
                div_v_reg[0] <= front_v_reg;
            end
            for (int k = 1; k <= DIV_STAGES; k++)
            begin
                if (div_rdy[k])
                begin
                    div_v_reg[k] <= div_v_reg[k-1];
                end
            end
            if (out_rdy)
            begin
                out_v_reg <= div_v_reg[DIV_STAGES];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (front_rdy)
        begin
            front_reg <= front_next;
        end
        for (int k = 0; k <= DIV_STAGES; k++)
        begin
            if (div_rdy[k])
            begin
                div_reg[k] <= div_next[k];
            end
        end
        if (out_rdy)
        begin
            hue_reg       <= hue_next;
            hue_valid_reg <= div_reg[DIV_STAGES].hv;
            sat_reg       <= sat_next;
            value_reg     <= div_reg[DIV_STAGES].value;
        end
    end

    assign hsv_valid  = out_v_reg;
    assign hue        = hue_reg;
    assign hue_valid  = hue_valid_reg;
    assign saturation = sat_reg;
    assign value      = value_reg;

endmodule

/* hw/rtl/rhc_checker.sv */
// Port-level checks for the RGB to HSV converter, bound to the top level.
module rhc_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      hsv_valid,
    input logic                      hsv_stall,
    input logic [rhc_pkg::HUE_W-1:0] hue,
    input logic                      hue_valid,
    input logic [rhc_pkg::SAT_W-1:0] saturation,
    input logic [rhc_pkg::CH_W-1:0]  value
);
    import rhc_pkg::*;

    // hold a stalled word
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid && hsv_stall |=> hsv_valid && $stable(hue) && $stable(saturation)
            && $stable(value) && $stable(hue_valid))
        else $error("stalled output word changed or dropped");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid |-> (hue < HUE_W'(HUE_FULL)) && (saturation <= SAT_W'(1 << SAT_SHIFT)))
        else $error("hue or saturation out of range");

    a_undef_hue: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid && !hue_valid |-> (hue == '0) && (saturation == '0))
        else $error("undefined hue with nonzero hue or saturation");

    a_def_hue: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid && hue_valid |-> (value != '0) && (saturation != '0))
        else $error("defined hue on black or grey pixel");

endmodule

bind rgb_to_hsv_convert_top rhc_checker u_rhc_checker (.*);
